[rtl/core/async_event_request_matcher_macros.svh]
`ifndef ASYNC_EVENT_REQUEST_MATCHER_MACROS_SVH
`define ASYNC_EVENT_REQUEST_MATCHER_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define AERM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define AERM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/aerm_pkg.sv]
package aerm_pkg;

    localparam logic [1:0] OP_SUBMIT = 2'd0;
    localparam logic [1:0] OP_POST   = 2'd1;
    localparam logic [1:0] OP_ABORT  = 2'd2;

    localparam int ACT_W = 4;
    localparam logic [ACT_W-1:0] ACT_NONE        = 4'd0;
    localparam logic [ACT_W-1:0] ACT_SUB_MATCH   = 4'd1;
    localparam logic [ACT_W-1:0] ACT_SUB_QUEUE   = 4'd2;
    localparam logic [ACT_W-1:0] ACT_SUB_REJECT  = 4'd3;
    localparam logic [ACT_W-1:0] ACT_POST_MATCH  = 4'd4;
    localparam logic [ACT_W-1:0] ACT_POST_BUFFER = 4'd5;
    localparam logic [ACT_W-1:0] ACT_ABORT_EMPTY = 4'd6;
    localparam logic [ACT_W-1:0] ACT_ABORT_START = 4'd7;
    localparam logic [ACT_W-1:0] ACT_ABORT_POP   = 4'd8;
    localparam logic [ACT_W-1:0] ACT_NOP_RESULT  = 4'd9;

    localparam logic [3:0] MAX_RESULTS = 4'd8;
    localparam logic [2:0] TYPE_MASK   = 3'h7;
    localparam logic [7:0] BYTE_MASK   = 8'hFF;

    typedef struct packed {
        logic             capture;
        logic             load_out;
        logic [ACT_W-1:0] act;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       id_empty;
        logic       id_full;
        logic       ev_empty;
        logic       emit_zero;
        logic       abort_last;
    } sts_t;

endpackage

[rtl/core/aerm_ctrl.sv]
`include "async_event_request_matcher_macros.svh"

module aerm_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    output logic          result_valid,
    input  logic          result_stall,
    input  aerm_pkg::sts_t sts,
    output aerm_pkg::cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_ABORT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign slot_free    = !out_valid_reg || !result_stall;
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.act    = aerm_pkg::ACT_NONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                    unique case (sts.op)
                        aerm_pkg::OP_SUBMIT:
                        begin
                            if (!sts.ev_empty)
                                cmd.act = aerm_pkg::ACT_SUB_MATCH;
                            else if (sts.id_full)
                                cmd.act = aerm_pkg::ACT_SUB_REJECT;
                            else
                                cmd.act = aerm_pkg::ACT_SUB_QUEUE;
                        end
                        aerm_pkg::OP_POST:
                        begin
                            if (!sts.id_empty)
                                cmd.act = aerm_pkg::ACT_POST_MATCH;
                            else
                                cmd.act = aerm_pkg::ACT_POST_BUFFER;
                        end
                        aerm_pkg::OP_ABORT:
                        begin
                            if (sts.emit_zero)
                                cmd.act = aerm_pkg::ACT_ABORT_EMPTY;
                            else
                            begin
                                cmd.act      = aerm_pkg::ACT_ABORT_START;
                                cmd.load_out = 1'b0;
                                state_next   = S_ABORT;
                            end
                        end
                        default:
                            cmd.act = aerm_pkg::ACT_NOP_RESULT;
                    endcase
                end
            end
            S_ABORT:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.act      = aerm_pkg::ACT_ABORT_POP;
                    if (sts.abort_last)
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (result_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    `AERM_ASSERT_SAME(a_load_needs_slot, cmd.load_out, !out_valid_reg || !result_stall,
        "Result loaded over an untaken transfer.")
    `AERM_ASSERT_NEXT(a_accept_to_exec, state_reg == S_IDLE && item_valid,
        state_reg == S_EXEC, "Accepted transfer did not start execution.")
    `AERM_ASSERT_SAME(a_stall_when_busy, state_reg == S_ABORT, item_stall && !cmd.capture,
        "Input taken while an abort is emitting.")

endmodule

[rtl/core/aerm_dp.sv]
`include "async_event_request_matcher_macros.svh"

module aerm_dp
#(
    parameter int REQUEST_DEPTH = 8,
    parameter int EVENT_DEPTH   = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  aerm_pkg::cmd_t cmd,
    output aerm_pkg::sts_t sts,
    input  logic [1:0]     opcode,
    input  logic [15:0]    req_id,
    input  logic [2:0]     event_type,
    input  logic [7:0]     event_info,
    input  logic [7:0]     log_page,
    input  logic [3:0]     abort_limit,
    output logic           has_completion,
    output logic [15:0]    completed_id,
    output logic [23:0]    completion_word,
    output logic           completion_status,
    output logic           request_rejected,
    output logic           last,
    output logic [3:0]     waiting_ids,
    output logic [4:0]     buffered_events,
    output logic [3:0]     aborted_total
);

    localparam int RI_W = (REQUEST_DEPTH > 1) ? $clog2(REQUEST_DEPTH) : 1;
    localparam int RC_W = $clog2(REQUEST_DEPTH + 1);
    localparam int EI_W = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
    localparam int EC_W = $clog2(EVENT_DEPTH + 1);
    localparam logic [RC_W:0] RDEPTH = (RC_W + 1)'(REQUEST_DEPTH);
    localparam logic [EC_W:0] EDEPTH = (EC_W + 1)'(EVENT_DEPTH);
    localparam logic [RI_W-1:0] RLAST = RI_W'(REQUEST_DEPTH - 1);
    localparam logic [EI_W-1:0] ELAST = EI_W'(EVENT_DEPTH - 1);

    logic [15:0] id_mem [REQUEST_DEPTH];
    logic [18:0] ev_mem [EVENT_DEPTH];

    logic [RI_W-1:0] id_head_reg, id_head_next;
    logic [RC_W-1:0] id_count_reg, id_count_next;
    logic [EI_W-1:0] ev_head_reg, ev_head_next;
    logic [EC_W-1:0] ev_count_reg, ev_count_next;
    logic [3:0]      abort_left_reg, abort_left_next;
    logic [3:0]      total_reg, total_next;

    logic [1:0]  op_reg;
    logic [15:0] cid_reg;
    logic [2:0]  etype_reg;
    logic [7:0]  einfo_reg;
    logic [7:0]  elog_reg;
    logic [3:0]  limit_reg;
    logic [15:0] id_q_reg;
    logic [18:0] ev_q_reg;

    logic        has_reg, has_next;
    logic [15:0] cid_out_reg, cid_out_next;
    logic [23:0] word_reg, word_next;
    logic        status_reg, status_next;
    logic        rej_reg, rej_next;
    logic        last_reg, last_next;
    logic [3:0]  waiting_reg, waiting_next;
    logic [4:0]  buffered_reg, buffered_next;
    logic [3:0]  aborted_reg, aborted_next;

    logic            id_we;
    logic [RI_W-1:0] id_waddr;
    logic            ev_we;
    logic [EI_W-1:0] ev_waddr;
    logic [RC_W:0]   id_sum;
    logic [EC_W:0]   ev_sum;
    logic [RI_W-1:0] id_tail;
    logic [EI_W-1:0] ev_tail;
    logic [RI_W-1:0] id_head_inc;
    logic [EI_W-1:0] ev_head_inc;
    logic [7:0]      cnt_ext;
    logic [3:0]      cnt_cap;
    logic [3:0]      emit;
    logic            id_full;
    logic            ev_full;

    assign id_sum      = (RC_W + 1)'(id_head_reg) + (RC_W + 1)'(id_count_reg);
    assign ev_sum      = (EC_W + 1)'(ev_head_reg) + (EC_W + 1)'(ev_count_reg);
    assign id_tail     = (id_sum >= RDEPTH) ? RI_W'(id_sum - RDEPTH) : RI_W'(id_sum);
    assign ev_tail     = (ev_sum >= EDEPTH) ? EI_W'(ev_sum - EDEPTH) : EI_W'(ev_sum);
    assign id_head_inc = (id_head_reg == RLAST) ? '0 : id_head_reg + 1'b1;
    assign ev_head_inc = (ev_head_reg == ELAST) ? '0 : ev_head_reg + 1'b1;
    assign id_full     = ((RC_W + 1)'(id_count_reg) == RDEPTH);
    assign ev_full     = ((EC_W + 1)'(ev_count_reg) == EDEPTH);

    assign cnt_ext = 8'(id_count_reg);
    assign cnt_cap = (cnt_ext > 8'(aerm_pkg::MAX_RESULTS)) ? aerm_pkg::MAX_RESULTS
                                                          : cnt_ext[3:0];
    assign emit    = (limit_reg < cnt_cap) ? limit_reg : cnt_cap;

    assign sts.op         = op_reg;
    assign sts.id_empty   = (id_count_reg == '0);
    assign sts.id_full    = id_full;
    assign sts.ev_empty   = (ev_count_reg == '0);
    assign sts.emit_zero  = (emit == 4'd0);
    assign sts.abort_last = (abort_left_reg == 4'd1);

    always_comb
    begin
        id_head_next    = id_head_reg;
        id_count_next   = id_count_reg;
        ev_head_next    = ev_head_reg;
        ev_count_next   = ev_count_reg;
        abort_left_next = abort_left_reg;
        total_next      = total_reg;
        id_we           = 1'b0;
        id_waddr        = id_tail;
        ev_we           = 1'b0;
        ev_waddr        = ev_tail;
        has_next        = 1'b0;
        cid_out_next    = '0;
        word_next       = '0;
        status_next     = 1'b0;
        rej_next        = 1'b0;
        last_next       = 1'b1;
        aborted_next    = '0;
        unique case (cmd.act)
            aerm_pkg::ACT_NONE:
            begin
            end
            aerm_pkg::ACT_SUB_MATCH:
            begin
                ev_head_next  = ev_head_inc;
                ev_count_next = ev_count_reg - 1'b1;
                has_next      = 1'b1;
                cid_out_next  = cid_reg;
                word_next     = {ev_q_reg[18:11] & aerm_pkg::BYTE_MASK,
                                 ev_q_reg[10:3] & aerm_pkg::BYTE_MASK,
                                 5'd0, ev_q_reg[2:0] & aerm_pkg::TYPE_MASK};
            end
            aerm_pkg::ACT_SUB_QUEUE:
            begin
                id_we         = 1'b1;
                id_count_next = id_count_reg + 1'b1;
            end
            aerm_pkg::ACT_SUB_REJECT:
            begin
                rej_next = 1'b1;
            end
            aerm_pkg::ACT_POST_MATCH:
            begin
                id_head_next  = id_head_inc;
                id_count_next = id_count_reg - 1'b1;
                has_next      = 1'b1;
                cid_out_next  = id_q_reg;
                word_next     = {elog_reg, einfo_reg, 5'd0, etype_reg};
            end
            aerm_pkg::ACT_POST_BUFFER:
            begin
                ev_we = 1'b1;
                if (ev_full)
                begin
                    ev_waddr     = ev_head_reg;
                    ev_head_next = ev_head_inc;
                end
                else
                    ev_count_next = ev_count_reg + 1'b1;
            end
            aerm_pkg::ACT_ABORT_EMPTY:
            begin
                id_head_next  = '0;
                id_count_next = '0;
                aborted_next  = 4'(id_count_reg);
            end
            aerm_pkg::ACT_ABORT_START:
            begin
                abort_left_next = emit;
                total_next      = 4'(id_count_reg);
            end
            aerm_pkg::ACT_ABORT_POP:
            begin
                abort_left_next = abort_left_reg - 1'b1;
                has_next        = 1'b1;
                cid_out_next    = id_q_reg;
                status_next     = 1'b1;
                last_next       = (abort_left_reg == 4'd1);
                aborted_next    = total_reg;
                if (abort_left_reg == 4'd1)
                begin
                    id_head_next  = '0;
                    id_count_next = '0;
                end
                else
                    id_head_next = id_head_inc;
            end
            aerm_pkg::ACT_NOP_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
        waiting_next  = (cmd.act == aerm_pkg::ACT_ABORT_POP) ? 4'd0 : 4'(id_count_next);
        buffered_next = 5'(ev_count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_head_reg    <= '0;
            id_count_reg   <= '0;
            ev_head_reg    <= '0;
            ev_count_reg   <= '0;
            abort_left_reg <= '0;
        end
        else
        begin
            id_head_reg    <= id_head_next;
            id_count_reg   <= id_count_next;
            ev_head_reg    <= ev_head_next;
            ev_count_reg   <= ev_count_next;
            abort_left_reg <= abort_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        if (cmd.capture)
        begin
            op_reg    <= opcode;
            cid_reg   <= req_id;
            etype_reg <= event_type;
            einfo_reg <= event_info;
            elog_reg  <= log_page;
            limit_reg <= abort_limit;
        end
        if (cmd.load_out)
        begin
            has_reg      <= has_next;
            cid_out_reg  <= cid_out_next;
            word_reg     <= word_next;
            status_reg   <= status_next;
            rej_reg      <= rej_next;
            last_reg     <= last_next;
            waiting_reg  <= waiting_next;
            buffered_reg <= buffered_next;
            aborted_reg  <= aborted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (id_we)
            id_mem[id_waddr] <= cid_reg;
        id_q_reg <= id_mem[id_head_next];
    end

    always_ff @(posedge clk)
    begin
        if (ev_we)
            ev_mem[ev_waddr] <= {elog_reg, einfo_reg, etype_reg};
        ev_q_reg <= ev_mem[ev_head_next];
    end

    assign has_completion    = has_reg;
    assign completed_id      = cid_out_reg;
    assign completion_word   = word_reg;
    assign completion_status = status_reg;
    assign request_rejected  = rej_reg;
    assign last              = last_reg;
    assign waiting_ids       = waiting_reg;
    assign buffered_events   = buffered_reg;
    assign aborted_total     = aborted_reg;

    `AERM_ASSERT_SAME(a_counts_in_range, 1'b1,
        (RC_W + 1)'(id_count_reg) <= RDEPTH && (EC_W + 1)'(ev_count_reg) <= EDEPTH,
        "Ring count beyond its depth.")
    `AERM_ASSERT_NEXT(a_abort_clears_ids,
        cmd.act == aerm_pkg::ACT_ABORT_POP && abort_left_reg == 4'd1,
        id_count_reg == '0 && id_head_reg == '0, "Abort left ids waiting.")
    `AERM_ASSERT_SAME(a_pop_has_left, cmd.act == aerm_pkg::ACT_ABORT_POP,
        abort_left_reg != 4'd0 && id_count_reg != '0, "Abort pop with nothing left.")

endmodule

[rtl/core/async_event_request_matcher.sv]
// Matches event-request command ids against posted device events.
// Input channel: item_valid/item_stall carry opcode, req_id, event_type,
// event_info, log_page and abort_limit; a transfer happens when item_valid is
// high and item_stall is low. Output channel: result_valid/result_stall carry
// one result per transfer, and last marks the final result of an input.
// A submit or post registers its fields on transfer and is then decoded into
// a result; item_stall stays high until that result is loaded, so a new item
// is not taken before the last one is done. The result sits in an output
// register and the next item is taken while it waits. An abort first sets up
// its count and then emits one aborted completion per cycle while the output
// is not stalled (at most eight completions). The id and event rings are
// memories with a registered read port that follows the ring head.
// Reset clears both rings' heads and counts; ring contents are not cleared.
// When result_stall is high the result holds; the block still takes one more
// item and then keeps item_stall high until the waiting result is taken.
module async_event_request_matcher
#(
    parameter int REQUEST_DEPTH = 8,
    parameter int EVENT_DEPTH   = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] req_id,
    input  logic [2:0]  event_type,
    input  logic [7:0]  event_info,
    input  logic [7:0]  log_page,
    input  logic [3:0]  abort_limit,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        has_completion,
    output logic [15:0] completed_id,
    output logic [23:0] completion_word,
    output logic        completion_status,
    output logic        request_rejected,
    output logic        last,
    output logic [3:0]  waiting_ids,
    output logic [4:0]  buffered_events,
    output logic [3:0]  aborted_total
);

    aerm_pkg::cmd_t cmd;
    aerm_pkg::sts_t sts;

    aerm_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    aerm_dp
    #(
        .REQUEST_DEPTH (REQUEST_DEPTH),
        .EVENT_DEPTH   (EVENT_DEPTH)
    )
    u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .opcode            (opcode),
        .req_id            (req_id),
        .event_type        (event_type),
        .event_info        (event_info),
        .log_page          (log_page),
        .abort_limit       (abort_limit),
        .has_completion    (has_completion),
        .completed_id      (completed_id),
        .completion_word   (completion_word),
        .completion_status (completion_status),
        .request_rejected  (request_rejected),
        .last              (last),
        .waiting_ids       (waiting_ids),
        .buffered_events   (buffered_events),
        .aborted_total     (aborted_total)
    );

endmodule
